@@ rtl/bsb_pkg.sv @@
// Shared types and constants for the brush stamp saturating blend block.
// Holds the transaction payload structs, the operation and register codes,
// and the control group handed to the channel blend unit. No dependencies.
`default_nettype none

package bsb_pkg;

  localparam int unsigned TEX_DIM_MAX_DEF   = 256;
  localparam int unsigned BRUSH_DIM_MAX_DEF = 16;

  typedef enum logic [1:0] {
    OP_BRUSH_WR = 2'd0,
    OP_TEX_WR   = 2'd1,
    OP_TEX_RD   = 2'd2,
    OP_STAMP    = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TEX_W   = 3'd0;
  localparam logic [2:0] CFG_TEX_H   = 3'd1;
  localparam logic [2:0] CFG_BRUSH_W = 3'd2;
  localparam logic [2:0] CFG_BRUSH_H = 3'd3;
  localparam logic [2:0] CFG_CHANNEL = 3'd4;

  typedef struct packed {
    op_e         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        erase;
    logic [7:0]  brush_index;
    logic [7:0]  brush_value;
    logic [31:0] texel_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [8:0]  painted_count;
  } out_t;

  typedef struct packed {
    logic [1:0] channel;
    logic       erase;
  } blend_ctl_t;

endpackage

`default_nettype wire

@@ rtl/bsb_blend.sv @@
// Saturating add or subtract of one brush sample into one byte of a texel.
// Depends on bsb_pkg for the blend control group.
`default_nettype none

module bsb_blend
  import bsb_pkg::*;
(
  input  wire logic [31:0] word_i,
  input  wire logic [7:0]  sample_i,
  input  var  blend_ctl_t  ctl_i,
  output logic      [31:0] word_o
);

  logic [7:0] old_byte;
  logic [7:0] new_byte;
  logic [8:0] sum;

  always_comb begin
    old_byte = word_i[{ctl_i.channel, 3'b000} +: 8];
    if (ctl_i.erase) begin
      sum      = {1'b0, old_byte} - {1'b0, sample_i};
      // A borrow out of the byte means the result went below zero.
      new_byte = sum[8] ? 8'h00 : sum[7:0];
    end else begin
      sum      = {1'b0, old_byte} + {1'b0, sample_i};
      new_byte = sum[8] ? 8'hFF : sum[7:0];
    end
    word_o = word_i;
    word_o[{ctl_i.channel, 3'b000} +: 8] = new_byte;
  end

endmodule

`default_nettype wire

@@ rtl/brush_stamp_saturating_blend.sv @@
// Top level of the brush stamp saturating blend block: texture and brush
// memories, stamp sequencer and read-modify-write pipeline.
// Depends on bsb_pkg and bsb_blend.
//
// Usage: one input transaction carries an operation (write brush sample,
// write texel, read texel, stamp) and gives exactly one output transaction.
// in_stall_o is high while an item is in progress; the block takes one item
// at a time. A stamp walks the brush one texel per cycle through a single
// read port and a single write port of the texture memory (read, blend,
// write back). Results sit in an output register, so the next item is
// accepted while a result still waits; a finished item whose result cannot
// be placed waits until the receiver takes the earlier one. Stalling the
// output never loses or repeats a result.
// Reset sets the registers to 256, 256, 16, 16 and channel 0 and empties the
// pipeline. The memories are not cleared; entries are defined once written.
// Configuration writes are taken at any edge with cfg_we_i high; the user must
// make them only while the block is idle, as the block does not enforce this.
`default_nettype none

module brush_stamp_saturating_blend
  import bsb_pkg::*;
#(
  parameter int unsigned TEX_DIM_MAX   = TEX_DIM_MAX_DEF,
  parameter int unsigned BRUSH_DIM_MAX = BRUSH_DIM_MAX_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  var  in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_t            out_data_o
);

  localparam int unsigned TEX_WORDS     = TEX_DIM_MAX * TEX_DIM_MAX;
  localparam int unsigned AW            = $clog2(TEX_WORDS);
  localparam int unsigned PW            = (AW > 19) ? AW : 19;
  localparam int unsigned BRUSH_SAMPLES = BRUSH_DIM_MAX * BRUSH_DIM_MAX;
  localparam int unsigned SAW           = (BRUSH_SAMPLES > 1) ? $clog2(BRUSH_SAMPLES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic [8:0] tex_w_q, tex_h_q;
  logic [4:0] brush_w_q, brush_h_q;
  logic [1:0] channel_q;

  logic [8:0] tw, th;
  logic [4:0] bw, bh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q   <= 9'd256;
      tex_h_q   <= 9'd256;
      brush_w_q <= 5'd16;
      brush_h_q <= 5'd16;
      channel_q <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEX_W:   tex_w_q   <= cfg_data_i;
        CFG_TEX_H:   tex_h_q   <= cfg_data_i;
        CFG_BRUSH_W: brush_w_q <= cfg_data_i[4:0];
        CFG_BRUSH_H: brush_h_q <= cfg_data_i[4:0];
        CFG_CHANNEL: channel_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Sizes above the built storage are taken as the storage limit.
  assign tw = (32'(tex_w_q) > 32'(TEX_DIM_MAX)) ? 9'(TEX_DIM_MAX) : tex_w_q;
  assign th = (32'(tex_h_q) > 32'(TEX_DIM_MAX)) ? 9'(TEX_DIM_MAX) : tex_h_q;
  assign bw = (32'(brush_w_q) > 32'(BRUSH_DIM_MAX)) ? 5'(BRUSH_DIM_MAX) : brush_w_q;
  assign bh = (32'(brush_h_q) > 32'(BRUSH_DIM_MAX)) ? 5'(BRUSH_DIM_MAX) : brush_h_q;

  // Item held while it is in progress.
  state_e      state_q;
  op_e         op_q;
  logic        erase_q;
  logic [7:0]  x_q, y_q;
  logic [31:0] tdata_q;
  logic [9:0]  x0_q, y0_q;
  logic [4:0]  col_q, row_q;
  logic [SAW-1:0] samp_q;
  logic [31:0] rdata_q;
  logic [8:0]  count_q;
  logic        out_valid_q;
  out_t        out_q;

  logic in_acc;
  logic issue;
  logic step_last;

  // Pipeline: stage 1 holds texel coordinates, stage 2 the address and the
  // memory reads, stage 3 the blend and write back.
  logic           p1_v_q, p2_v_q, p3_v_q;
  logic [9:0]     p1_tx_q, p1_ty_q;
  logic [SAW-1:0] p1_samp_q, p2_samp_q;
  logic           p2_ok_q, p3_ok_q;
  logic [AW-1:0]  p2_addr_q, p3_addr_q;
  logic           p2_ok_d;
  logic [PW-1:0]  prod;
  logic [9:0]     tx_d, ty_d;

  logic [31:0] tex_mem [TEX_WORDS];
  logic [7:0]  brush_mem [BRUSH_SAMPLES];
  logic [31:0] tex_rd_q;
  logic [7:0]  brush_rd_q;
  logic [31:0] blend_word;
  logic [31:0] wr_word;
  logic        tex_we;

  blend_ctl_t blend_ctl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_RUN);
  assign step_last  = (op_q != OP_STAMP) ||
                      ((row_q == bh - 5'd1) && (col_q == bw - 5'd1));

  always_comb begin
    if (op_q == OP_STAMP) begin
      tx_d = x0_q + {5'b0, col_q};
      ty_d = y0_q + {5'b0, row_q};
    end else begin
      tx_d = {2'b0, x_q};
      ty_d = {2'b0, y_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      col_q       <= 5'd0;
      row_q       <= 5'd0;
      samp_q      <= '0;
      rdata_q     <= 32'd0;
      count_q     <= 9'd0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (p3_v_q && p3_ok_q) begin
        if (op_q == OP_TEX_RD) begin
          rdata_q <= tex_rd_q;
        end
        if (op_q == OP_STAMP) begin
          count_q <= count_q + 9'd1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            col_q   <= 5'd0;
            row_q   <= 5'd0;
            samp_q  <= '0;
            rdata_q <= 32'd0;
            count_q <= 9'd0;
            case (in_data_i.op)
              OP_BRUSH_WR: state_q <= ST_DONE;
              OP_STAMP:    state_q <= (bw == 5'd0 || bh == 5'd0) ? ST_DRAIN : ST_RUN;
              default:     state_q <= ST_RUN;
            endcase
          end
        end
        ST_RUN: begin
          samp_q <= samp_q + SAW'(1);
          if (row_q == bh - 5'd1) begin
            row_q <= 5'd0;
            col_q <= col_q + 5'd1;
          end else begin
            row_q <= row_q + 5'd1;
          end
          if (step_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_v_q && !p2_v_q && !p3_v_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.read_data     <= rdata_q;
            out_q.painted_count <= count_q;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item fields and stamp origin: the first column is the centre minus half
  // the width, plus one when the width is even.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_data_i.op;
      erase_q <= in_data_i.erase;
      x_q     <= in_data_i.x;
      y_q     <= in_data_i.y;
      tdata_q <= in_data_i.texel_data;
      x0_q    <= {2'b0, in_data_i.x} - {6'b0, bw[4:1]} + {9'b0, ~bw[0]};
      y0_q    <= {2'b0, in_data_i.y} - {6'b0, bh[4:1]} + {9'b0, ~bh[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  // Negative coordinates show as the top bit of the 10-bit value.
  assign p2_ok_d = !p1_tx_q[9] && !p1_ty_q[9] &&
                   (p1_tx_q[8:0] < tw) && (p1_ty_q[8:0] < th);
  assign prod    = PW'(p1_ty_q[8:0]) * PW'(tw) + PW'(p1_tx_q[8:0]);

  always_ff @(posedge clk_i) begin
    p1_tx_q   <= tx_d;
    p1_ty_q   <= ty_d;
    p1_samp_q <= samp_q;
    p2_ok_q   <= p2_ok_d;
    p2_addr_q <= prod[AW-1:0];
    p2_samp_q <= p1_samp_q;
    p3_ok_q   <= p2_ok_q;
    p3_addr_q <= p2_addr_q;
  end

  // Memory read ports. Texels within one stamp are distinct, so a read never
  // meets the write back of the same entry.
  always_ff @(posedge clk_i) begin
    if (p2_v_q && p2_ok_q) begin
      tex_rd_q <= tex_mem[p2_addr_q];
    end
    if (p2_v_q) begin
      brush_rd_q <= brush_mem[p2_samp_q];
    end
  end

  assign blend_ctl.channel = channel_q;
  assign blend_ctl.erase   = erase_q;

  bsb_blend u_blend (
    .word_i   (tex_rd_q),
    .sample_i (brush_rd_q),
    .ctl_i    (blend_ctl),
    .word_o   (blend_word)
  );

  assign wr_word = (op_q == OP_TEX_WR) ? tdata_q : blend_word;
  assign tex_we  = p3_v_q && p3_ok_q && (op_q != OP_TEX_RD);

  always_ff @(posedge clk_i) begin
    if (tex_we) begin
      tex_mem[p3_addr_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.op == OP_BRUSH_WR &&
        32'(in_data_i.brush_index) < 32'(BRUSH_SAMPLES)) begin
      brush_mem[SAW'(in_data_i.brush_index)] <= in_data_i.brush_value;
    end
  end

  // Steps enter the pipeline only while the sequencer runs.
  a_issue_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_v_q |-> $past(state_q == ST_RUN))
    else $error("pipeline step without a running item");

  // The result is formed only after the pipeline has emptied.
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!p1_v_q && !p2_v_q && !p3_v_q))
    else $error("result formed with steps still in flight");

  // Back-to-back write backs go to different texels.
  a_distinct_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tex_we && $past(tex_we)) |-> (p3_addr_q != $past(p3_addr_q)))
    else $error("write back overlaps the previous one");

  // A result never carries both read data and a painted count.
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.read_data == 32'd0 || out_q.painted_count == 9'd0))
    else $error("result has both read data and a count");

endmodule

`default_nettype wire
